// ===== design/fraction_arith_reduce_macros.svh =====
// Assertion macros used by the checker in fra_check.sv.
`ifndef FRACTION_ARITH_REDUCE_MACROS_SVH
`define FRACTION_ARITH_REDUCE_MACROS_SVH

// Same-cycle implication, disabled while the given condition holds.
`define FRA_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while the given condition holds.
`define FRA_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fra_pkg.sv =====
package fra_pkg;

    localparam int RES_W = 33;

    localparam logic [1:0] OP_MUL = 2'd0;
    localparam logic [1:0] OP_ADD = 2'd1;
    localparam logic [1:0] OP_RED = 2'd2;

    typedef struct packed {
        logic start;
        logic ack;
    } red_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } red_stat_t;

endpackage

// ===== design/fra_red.sv =====
module fra_red #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  fra_pkg::red_ctrl_t       ctrl,
    input  logic [OPERAND_WIDTH-1:0] num_mag,
    input  logic [OPERAND_WIDTH-1:0] den_mag,
    output fra_pkg::red_stat_t       stat,
    output logic [OPERAND_WIDTH-1:0] num_q,
    output logic [OPERAND_WIDTH-1:0] den_q
);

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } red_state_t;

    red_state_t     state_reg;
    logic [W-1:0]   u_reg;
    logic [W-1:0]   v_reg;
    logic [KW-1:0]  k_reg;
    logic [W-1:0]   g_reg;
    logic [W-1:0]   qn_reg;
    logic [W-1:0]   qd_reg;
    logic [W:0]     rn_reg;
    logic [W:0]     rd_reg;
    logic [KW-1:0]  cnt_reg;

    logic [W:0]     rn_try;
    logic [W:0]     rd_try;
    logic           n_bit;
    logic           d_bit;

    assign rn_try = {rn_reg[W-1:0], qn_reg[W-1]};
    assign rd_try = {rd_reg[W-1:0], qd_reg[W-1]};
    assign n_bit  = (rn_try >= {1'b0, g_reg});
    assign d_bit  = (rd_try >= {1'b0, g_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.start)
                    begin
                        u_reg     <= num_mag;
                        v_reg     <= den_mag;
                        qn_reg    <= num_mag;
                        qd_reg    <= den_mag;
                        k_reg     <= '0;
                        state_reg <= ST_GCD;
                    end
                end
                ST_GCD:
                begin
                    rn_reg  <= '0;
                    rd_reg  <= '0;
                    cnt_reg <= '0;
                    if (u_reg == '0)
                    begin
                        g_reg     <= W'(v_reg << k_reg);
                        state_reg <= ST_DIV;
                    end
                    else if (v_reg == '0)
                    begin
                        g_reg     <= W'(u_reg << k_reg);
                        state_reg <= ST_DIV;
                    end
                    else if (!u_reg[0] && !v_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + 1'b1;
                    end
                    else if (!u_reg[0])
                    begin
                        u_reg <= u_reg >> 1;
                    end
                    else if (!v_reg[0])
                    begin
                        v_reg <= v_reg >> 1;
                    end
                    else if (u_reg >= v_reg)
                    begin
                        u_reg <= (u_reg - v_reg) >> 1;
                    end
                    else
                    begin
                        v_reg <= (v_reg - u_reg) >> 1;
                    end
                end
                ST_DIV:
                begin
                    rn_reg  <= n_bit ? (rn_try - {1'b0, g_reg}) : rn_try;
                    rd_reg  <= d_bit ? (rd_try - {1'b0, g_reg}) : rd_try;
                    qn_reg  <= {qn_reg[W-2:0], n_bit};
                    qd_reg  <= {qd_reg[W-2:0], d_bit};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == KW'(W - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (ctrl.ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != ST_IDLE);
    assign stat.done = (state_reg == ST_DONE);
    assign num_q     = qn_reg;
    assign den_q     = qd_reg;

endmodule

// ===== design/fraction_arith_reduce.sv =====
// Fraction arithmetic with reduction by the greatest common divisor.
// The input channel (in_valid/in_ready) carries an operation and two signed
// fractions; the output channel (out_valid/out_ready) returns one fraction
// per input transaction, in order.
// Multiply and add run through three register stages: input capture, the
// products, and the final sum in the output register. out_valid rises once
// an accepted transaction reaches the output register, and they sustain one
// transaction per cycle while out_ready stays high.
// Reduce holds the input stage while an iterative unit runs a binary
// greatest common divisor and then two restoring divisions in parallel.
// A reduce whose larger part is not positive passes straight through.
// Reset clears all valid bits and returns the reduce unit to idle.
// When the receiver stalls, the output register holds its transaction and
// the earlier stages fill up before in_ready drops; nothing is lost.
module fraction_arith_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      operation,
    input  logic signed [OPERAND_WIDTH-1:0] a_numerator,
    input  logic signed [OPERAND_WIDTH-1:0] a_denominator,
    input  logic signed [OPERAND_WIDTH-1:0] b_numerator,
    input  logic signed [OPERAND_WIDTH-1:0] b_denominator,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [fra_pkg::RES_W-1:0] result_numerator,
    output logic signed [fra_pkg::RES_W-1:0] result_denominator
);

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int RW = fra_pkg::RES_W;
    localparam int XW = (PW > RW) ? PW : RW;

    logic                  v1_reg, v2_reg, v3_reg;
    logic                  v1_next, v2_next, v3_next;
    logic [1:0]            op1_reg;
    logic signed [W-1:0]   an1_reg, ad1_reg, bn1_reg, bd1_reg;

    logic                  red2_reg, add2_reg;
    logic signed [2*W-1:0] pa2_reg, pb2_reg, pd2_reg;
    logic signed [RW-1:0]  rn2_reg, rd2_reg;

    logic signed [RW-1:0]  num3_reg, den3_reg;

    logic                  accept, st1_go, st2_free, st3_free;
    logic                  is_red, pos;
    logic [W-1:0]          mag_n, mag_d, q_n, q_d;
    logic signed [2*W-1:0] pa, pb, pd;
    logic signed [RW-1:0]  red_n, red_d;
    logic signed [PW-1:0]  nsum, dsum;
    logic signed [XW-1:0]  nx, dx;

    fra_pkg::red_ctrl_t    rctrl;
    fra_pkg::red_stat_t    rstat;

    assign is_red   = op1_reg[1];
    assign pos      = (an1_reg > 0) || (ad1_reg > 0);
    assign mag_n    = an1_reg[W-1] ? W'(-an1_reg) : W'(an1_reg);
    assign mag_d    = ad1_reg[W-1] ? W'(-ad1_reg) : W'(ad1_reg);

    assign st3_free = !v3_reg || out_ready;
    assign st2_free = !v2_reg || st3_free;
    assign st1_go   = v1_reg && st2_free && (!is_red || !pos || rstat.done);
    assign in_ready = !v1_reg || st1_go;
    assign accept   = in_valid && in_ready;

    assign rctrl.start = v1_reg && is_red && pos && !rstat.busy;
    assign rctrl.ack   = st1_go;

    fra_red #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_red (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (rctrl),
        .num_mag (mag_n),
        .den_mag (mag_d),
        .stat    (rstat),
        .num_q   (q_n),
        .den_q   (q_d)
    );

    assign pa = an1_reg * ((op1_reg == fra_pkg::OP_MUL) ? bn1_reg : bd1_reg);
    assign pb = ad1_reg * bn1_reg;
    assign pd = ad1_reg * bd1_reg;

    always_comb
    begin
        if (!pos)
        begin
            red_n = RW'(an1_reg);
            red_d = RW'(ad1_reg);
        end
        else
        begin
            red_n = an1_reg[W-1] ? -RW'(q_n) : RW'(q_n);
            red_d = ad1_reg[W-1] ? -RW'(q_d) : RW'(q_d);
        end
    end

    assign nsum = add2_reg ? (PW'(pa2_reg) + PW'(pb2_reg)) : PW'(pa2_reg);
    assign dsum = PW'(pd2_reg);
    assign nx   = XW'(nsum);
    assign dx   = XW'(dsum);

    assign v1_next = accept ? 1'b1 : (st1_go ? 1'b0 : v1_reg);
    assign v2_next = st1_go ? 1'b1 : (st3_free ? 1'b0 : v2_reg);
    assign v3_next = st3_free ? v2_reg : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op1_reg <= operation;
            an1_reg <= a_numerator;
            ad1_reg <= a_denominator;
            bn1_reg <= b_numerator;
            bd1_reg <= b_denominator;
        end
        if (st1_go)
        begin
            red2_reg <= is_red;
            add2_reg <= (op1_reg == fra_pkg::OP_ADD);
            pa2_reg  <= pa;
            pb2_reg  <= pb;
            pd2_reg  <= pd;
            rn2_reg  <= red_n;
            rd2_reg  <= red_d;
        end
        if (st3_free && v2_reg)
        begin
            num3_reg <= red2_reg ? rn2_reg : nx[RW-1:0];
            den3_reg <= red2_reg ? rd2_reg : dx[RW-1:0];
        end
    end

    assign out_valid          = v3_reg;
    assign result_numerator   = num3_reg;
    assign result_denominator = den3_reg;

endmodule

// ===== design/fra_check.sv =====
`include "fraction_arith_reduce_macros.svh"

module fra_check (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [fra_pkg::RES_W-1:0]     result_numerator,
    input logic [fra_pkg::RES_W-1:0]     result_denominator
);

    `FRA_ASSERT_NEXT(a_reset_empty, clk, 1'b0, !rst_n, !out_valid, "output valid after reset")
    `FRA_ASSERT_NOW(a_ready_drop, clk, !rst_n, $fell(in_ready), $past(in_valid), "in_ready fell")
    `FRA_ASSERT_NEXT(a_out_hold, clk, !rst_n, out_valid && !out_ready, out_valid, "out_valid dropped")
    `FRA_ASSERT_NEXT(a_out_stable, clk, !rst_n, out_valid && !out_ready, $stable(result_numerator) && $stable(result_denominator), "output changed")

endmodule

bind fraction_arith_reduce fra_check u_fra_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .result_numerator   (result_numerator),
    .result_denominator (result_denominator)
);

// ===== bench/tb_fraction_arith_reduce.sv =====
`timescale 1ns / 100ps

module tb_fraction_arith_reduce;

    localparam int W = 16;
    localparam int WW = fra_pkg::RES_W + 32;
    localparam int N_RANDOM = 2000;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic signed [fra_pkg::RES_W-1:0] num;
        logic signed [fra_pkg::RES_W-1:0] den;
    } fraction_t;

    class fraction_scoreboard;
        fraction_t pending[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function logic [W-1:0] gcd_of(logic [W:0] x, logic [W:0] y);
            logic [W:0] t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x[W-1:0];
        endfunction

        function void note_operation(logic [1:0] op, logic signed [W-1:0] an,
                                     logic signed [W-1:0] ad, logic signed [W-1:0] bn,
                                     logic signed [W-1:0] bd);
            fraction_t f;
            logic signed [WW-1:0] wn;
            logic signed [WW-1:0] wd;
            logic signed [W:0] xn;
            logic signed [W:0] xd;
            logic [W:0] mn;
            logic [W:0] md;
            logic [W:0] g;
            logic signed [W:0] larger;
            xn = (W+1)'(an);
            xd = (W+1)'(ad);
            if (op[1])
            begin
                larger = (xn > xd) ? xn : xd;
                if (larger > 0)
                begin
                    mn = (xn < 0) ? -xn : xn;
                    md = (xd < 0) ? -xd : xd;
                    g = {1'b0, gcd_of(mn, md)};
                    wn = WW'(mn / g);
                    wd = WW'(md / g);
                    if (xn < 0)
                        wn = -wn;
                    if (xd < 0)
                        wd = -wd;
                end
                else
                begin
                    wn = WW'(xn);
                    wd = WW'(xd);
                end
            end
            else if (op == fra_pkg::OP_MUL)
            begin
                wn = WW'(an) * WW'(bn);
                wd = WW'(ad) * WW'(bd);
            end
            else
            begin
                wn = WW'(an) * WW'(bd) + WW'(ad) * WW'(bn);
                wd = WW'(ad) * WW'(bd);
            end
            f.num = wn[fra_pkg::RES_W-1:0];
            f.den = wd[fra_pkg::RES_W-1:0];
            pending.push_back(f);
        endfunction

        function void check_result(logic signed [fra_pkg::RES_W-1:0] num,
                                   logic signed [fra_pkg::RES_W-1:0] den);
            fraction_t f;
            if (pending.size() == 0)
            begin
                $error("unexpected result %0d/%0d", num, den);
                errors++;
                return;
            end
            f = pending.pop_front();
            if (num !== f.num)
            begin
                $error("result_numerator expected %0d actual %0d", f.num, num);
                errors++;
            end
            if (den !== f.den)
            begin
                $error("result_denominator expected %0d actual %0d", f.den, den);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic [1:0] operation = '0;
    logic signed [W-1:0] a_numerator = '0;
    logic signed [W-1:0] a_denominator = '0;
    logic signed [W-1:0] b_numerator = '0;
    logic signed [W-1:0] b_denominator = '0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [fra_pkg::RES_W-1:0] result_numerator;
    logic signed [fra_pkg::RES_W-1:0] result_denominator;

    fraction_scoreboard board = new();
    int cycles = 0;
    bit quiet_phase = 0;

    fraction_arith_reduce #(.OPERAND_WIDTH(W)) dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("fraction_arith_reduce test failed");
            $finish;
        end
        if (rst_n && out_valid && out_ready)
            board.check_result(result_numerator, result_denominator);
    end

    always @(negedge clk)
        out_ready <= rst_n && (quiet_phase || $urandom_range(99) >= 34);

    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return 16'hffff;
            4, 5: return W'($signed($urandom_range(40)) - 20);
            6: return W'($urandom_range(255)) * W'($urandom_range(120));
            default: return W'($urandom);
        endcase
    endfunction

    task automatic send_fraction(logic [1:0] op, logic [W-1:0] an, logic [W-1:0] ad,
                                 logic [W-1:0] bn, logic [W-1:0] bd);
        while (!quiet_phase && $urandom_range(99) < 34)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        operation <= op;
        a_numerator <= an;
        a_denominator <= ad;
        b_numerator <= bn;
        b_denominator <= bd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_operation(op, an, ad, bn, bd);
        @(negedge clk);
    endtask

    initial
    begin
        logic [1:0] op;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        send_fraction(fra_pkg::OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fraction(fra_pkg::OP_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        send_fraction(fra_pkg::OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_fraction(fra_pkg::OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_fraction(fra_pkg::OP_ADD, W'(3), W'(0), W'(5), W'(0));
        send_fraction(fra_pkg::OP_MUL, W'(1), W'(0), W'(0), W'(7));
        send_fraction(fra_pkg::OP_RED, W'(12), W'(18), 16'hffff, 16'hffff);
        send_fraction(fra_pkg::OP_RED, W'(-12), W'(18), W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, W'(12), W'(-18), W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, W'(-12), W'(-18), W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, W'(0), W'(5), W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, W'(7), W'(0), W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, W'(0), W'(0), W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, W'(0), W'(-5), W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, 16'h8000, 16'h7fff, W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, 16'h7fff, 16'h8000, W'(0), W'(0));
        send_fraction(fra_pkg::OP_RED, 16'h8000, 16'h4000, W'(0), W'(0));
        send_fraction(2'd3, W'(30), W'(42), W'(1), W'(1));
        send_fraction(2'd3, 16'h7ffe, 16'h7fff, W'(1), W'(1));
        for (int i = 0; i < N_RANDOM; i++)
        begin
            quiet_phase = (i >= 800 && i < 1100);
            op = 2'($urandom_range(3));
            send_fraction(op, pick_operand(), pick_operand(), pick_operand(),
                          pick_operand());
        end
        in_valid <= 0;
        quiet_phase = 0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("fraction_arith_reduce test passed");
        else
            $display("fraction_arith_reduce test failed");
        $finish;
    end
endmodule
